FILE: rtl/core/rgbt_pkg.sv
// Shared types and constants for the RGB to tiled RGBA8 converter.
// Used by rgbt_ctrl, rgbt_datapath and the top level; no dependencies.
package rgbt_pkg;

    // Field and port widths
    localparam int PIX_W     = 24;
    localparam int WORD_W    = 64;
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 8;
    localparam int SEQ_W     = 3;

    // Default line length in pixels
    localparam int DEF_MAX_WIDTH = 1024;

    // Constant alpha byte
    localparam logic [7:0] ALPHA_BYTE = 8'hFF;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] REG_TILES_ACROSS = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BANDS_DOWN   = 8'd1;
    localparam logic [CFG_W-1:0]     TILES_RESET      = 9'd160;
    localparam logic [CFG_W-1:0]     BANDS_RESET      = 9'd120;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } ctrl_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic             wr_px;      // pixel accepted: write store, advance counters
        logic             rd_en;      // read one tile row into the tile buffer
        logic [1:0]       rd_row;
        logic             load_word;  // load next output word into output register
        logic [SEQ_W-1:0] word_idx;
    } rgbt_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic tile_now;   // next pixel completes a tile
        logic out_free;   // output register can take a word this cycle
    } rgbt_stat_t;

endpackage

FILE: rtl/core/rgbt_ctrl.sv
// Sequencing state machine: pixel accept, tile row reads, word emission.
// Depends on rgbt_pkg.
module rgbt_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  rgbt_pkg::rgbt_stat_t stat,
    output rgbt_pkg::rgbt_cmd_t  cmd
);

    rgbt_pkg::ctrl_state_t           state_reg, state_next;
    logic [rgbt_pkg::SEQ_W-1:0]      seq_reg, seq_next;
    logic                            accept;

    assign accept = s_tvalid && s_tready;

    // State and sequence registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rgbt_pkg::ST_IDLE;
            seq_reg   <= '0;
        end else begin
            state_reg <= state_next;
            seq_reg   <= seq_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        seq_next   = seq_reg;
        unique case (state_reg)
            rgbt_pkg::ST_IDLE: begin
                if (s_tvalid && stat.tile_now) begin
                    state_next = rgbt_pkg::ST_READ;
                    seq_next   = '0;
                end
            end
            rgbt_pkg::ST_READ: begin
                seq_next = seq_reg + 3'd1;
                if (seq_reg == 3'd3) begin
                    state_next = rgbt_pkg::ST_EMIT;
                    seq_next   = '0;
                end
            end
            rgbt_pkg::ST_EMIT: begin
                if (stat.out_free) begin
                    seq_next = seq_reg + 3'd1;
                    if (seq_reg == 3'd7) begin
                        state_next = rgbt_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = rgbt_pkg::ST_IDLE;
                seq_next   = '0;
            end
        endcase
    end

    // Outputs
    always_comb begin
        s_tready      = 1'b0;
        cmd.wr_px     = 1'b0;
        cmd.rd_en     = 1'b0;
        cmd.rd_row    = seq_reg[1:0];
        cmd.load_word = 1'b0;
        cmd.word_idx  = seq_reg;
        unique case (state_reg)
            rgbt_pkg::ST_IDLE: begin
                s_tready  = 1'b1;
                cmd.wr_px = s_tvalid;
            end
            rgbt_pkg::ST_READ: begin
                cmd.rd_en = 1'b1;
            end
            rgbt_pkg::ST_EMIT: begin
                // plain pixels go on while the tile drains
                s_tready      = !stat.tile_now;
                cmd.wr_px     = s_tvalid && !stat.tile_now;
                cmd.load_word = stat.out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // A tile-completing pixel always starts the row reads
    a_tile_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && stat.tile_now) |=> (state_reg == rgbt_pkg::ST_READ) && (seq_reg == 3'd0))
        else $error("tile pixel did not start row reads");

    // Tile buffer is not overwritten by a new tile while it drains
    a_no_tile_in_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == rgbt_pkg::ST_EMIT && stat.tile_now) |-> !cmd.wr_px)
        else $error("tile pixel taken during emission");

    // Emission follows exactly four row reads
    a_emit_after_read: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(state_reg == rgbt_pkg::ST_EMIT) |-> $past(cmd.rd_en) && ($past(cmd.rd_row) == 2'd3))
        else $error("emission without full tile read");

endmodule

FILE: rtl/core/rgbt_datapath.sv
// Datapath: config registers, raster counters, four-row line store,
// tile buffer and output register. Depends on rgbt_pkg.
module rgbt_datapath #(
    parameter int MAX_WIDTH = rgbt_pkg::DEF_MAX_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr,
    input  logic [rgbt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rgbt_pkg::CFG_W-1:0]     cfg_data,
    input  logic [rgbt_pkg::PIX_W-1:0]     s_tdata,
    input  rgbt_pkg::rgbt_cmd_t            cmd,
    output rgbt_pkg::rgbt_stat_t           stat,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rgbt_pkg::WORD_W-1:0]    m_tdata,
    output logic                           m_tlast,
    output logic                           m_tuser
);

    localparam int GROUPS = MAX_WIDTH / 4;
    localparam int GW     = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam int CW     = GW + 2;
    localparam int AW     = GW + 2;
    localparam int DEPTH  = 4 * (1 << GW);
    localparam int ROW_W  = 4 * rgbt_pkg::PIX_W;

    logic [rgbt_pkg::CFG_W-1:0] tiles_reg, bands_reg;
    logic [CW-1:0]              col_reg, col_next;
    logic [1:0]                 row_reg, row_next;
    logic [7:0]                 band_reg, band_next;
    logic [GW-1:0]              grp_reg;
    logic                       frame_end_reg;

    logic [12:0]                tiles_ext;
    logic [GW-1:0]              tiles_m1;
    logic [CW-1:0]              col_end;
    logic [7:0]                 bands_m1;
    logic                       col_wrap, band_last, tile_now;

    logic [ROW_W-1:0]           line_store_mem [DEPTH];
    logic [ROW_W-1:0]           tile_buf_reg [4];
    logic [AW-1:0]              wr_addr, rd_addr;
    logic [rgbt_pkg::PIX_W-1:0] pix;

    logic [ROW_W-1:0]           sel_row;
    logic [rgbt_pkg::WORD_W-1:0] ar_word, gb_word, word;

    logic                        m_tvalid_reg;
    logic [rgbt_pkg::WORD_W-1:0] m_tdata_reg;
    logic                        m_tlast_reg, m_tuser_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tiles_reg <= rgbt_pkg::TILES_RESET;
            bands_reg <= rgbt_pkg::BANDS_RESET;
        end else if (cfg_wr) begin
            unique case (cfg_index)
                rgbt_pkg::REG_TILES_ACROSS: tiles_reg <= cfg_data;
                rgbt_pkg::REG_BANDS_DOWN:   bands_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective width and height, clamped to 1..limit
    assign tiles_ext = 13'(tiles_reg);
    always_comb begin
        if (tiles_reg == '0) begin
            tiles_m1 = '0;
        end else if (tiles_ext > 13'(GROUPS)) begin
            tiles_m1 = GW'(GROUPS - 1);
        end else begin
            tiles_m1 = GW'(tiles_ext - 13'd1);
        end
    end

    always_comb begin
        if (bands_reg == '0) begin
            bands_m1 = 8'd0;
        end else if (bands_reg > 9'd256) begin
            bands_m1 = 8'd255;
        end else begin
            bands_m1 = 8'(bands_reg - 9'd1);
        end
    end

    assign col_end   = {tiles_m1, 2'b11};
    assign col_wrap  = (col_reg >= col_end);
    assign band_last = (band_reg >= bands_m1);
    assign tile_now  = (row_reg == 2'd3) && (col_reg[1:0] == 2'b11) && (col_reg <= col_end);

    assign stat.tile_now = tile_now;
    assign stat.out_free = !m_tvalid_reg || m_tready;

    // Raster counters
    always_comb begin
        col_next  = col_reg + 1'b1;
        row_next  = row_reg;
        band_next = band_reg;
        if (col_wrap) begin
            col_next = '0;
            if (row_reg == 2'd3) begin
                row_next  = 2'd0;
                band_next = band_last ? 8'd0 : band_reg + 8'd1;
            end else begin
                row_next = row_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            band_reg <= '0;
        end else if (cmd.wr_px) begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            band_reg <= band_next;
        end
    end

    // Tile position and frame-end flag, held for the row reads
    always_ff @(posedge aclk) begin
        if (cmd.wr_px && tile_now) begin
            grp_reg       <= col_reg[CW-1:2];
            frame_end_reg <= col_wrap && band_last;
        end
    end

    // Line store: one entry holds four pixels of one row of a tile column
    assign pix     = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
    assign wr_addr = {row_reg, col_reg[CW-1:2]};
    assign rd_addr = {cmd.rd_row, grp_reg};

    always_ff @(posedge aclk) begin
        if (cmd.wr_px) begin
            line_store_mem[wr_addr][col_reg[1:0]*rgbt_pkg::PIX_W +: rgbt_pkg::PIX_W] <= pix;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            tile_buf_reg[cmd.rd_row] <= line_store_mem[rd_addr];
        end
    end

    // Word build: alpha/red for words 0..3, green/blue for words 4..7
    assign sel_row = tile_buf_reg[cmd.word_idx[1:0]];
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            ar_word[63-16*k -: 16] = {rgbt_pkg::ALPHA_BYTE, sel_row[24*k+16 +: 8]};
            gb_word[63-16*k -: 16] = {sel_row[24*k+8 +: 8], sel_row[24*k +: 8]};
        end
    end
    assign word = cmd.word_idx[2] ? gb_word : ar_word;

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.load_word) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_word) begin
            m_tdata_reg <= word;
            m_tlast_reg <= (cmd.word_idx == 3'd7);
            m_tuser_reg <= (cmd.word_idx == 3'd7) && frame_end_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    // Frame end only marks the last word of a tile
    a_frame_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("frame end flag on a non-final word");

endmodule

FILE: rtl/core/rgb_to_rgba8_tile_swizzle.sv
// RGB raster to 4x4-tiled RGBA8 converter, top level.
// A tile-completing pixel starts the row reads (ST_READ), then word emission (ST_EMIT).
// Plain pixels are taken one per cycle outside ST_READ; a tile pixel stalls input while
// the four tile rows are read (single read port), then 8 words leave one per cycle unless
// m_tready holds them, as plain pixels go on; the next tile pixel waits for the last word.
// Reset: aresetn synchronous active low; counters and config reset, store undefined.
module rgb_to_rgba8_tile_swizzle #(
    parameter int MAX_WIDTH = rgbt_pkg::DEF_MAX_WIDTH
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rgbt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rgbt_pkg::CFG_W-1:0]     cfg_data,
    // pixel input
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rgbt_pkg::PIX_W-1:0]     s_tdata,   // red [7:0], green [15:8], blue [23:16]
    // tile word output
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rgbt_pkg::WORD_W-1:0]    m_tdata,   // tile_word [63:0]
    output logic                           m_tlast,   // tile_last
    output logic                           m_tuser    // frame_last [0]
);

    rgbt_pkg::rgbt_cmd_t  cmd;
    rgbt_pkg::rgbt_stat_t stat;

    assign cfg_ready = 1'b1;

    rgbt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rgbt_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule
